// ----- hdl/bba_pkg.sv -----
// Shared types, codes and constants of the block bitmap allocator.
package bba_pkg;

   // Field and register widths
   localparam int CFG_W    = 16;
   localparam int BLOCK_W  = 15;
   localparam int OP_W     = 2;
   localparam int STATUS_W = 2;

   // Default geometry of the map (word width must be a power of two)
   localparam int DEF_TOTAL_BLOCKS  = 32768;
   localparam int DEF_MAP_WORD_BITS = 64;

   // Register reset values
   localparam logic [CFG_W-1:0] MANAGED_RESET  = 16'd32768;
   localparam logic [CFG_W-1:0] RESERVED_RESET = 16'd3;

   // Register indexes
   localparam logic CSR_MANAGED  = 1'b0;
   localparam logic CSR_RESERVED = 1'b1;

   typedef enum logic [OP_W-1:0] {
      OP_ALLOC   = 2'd0,
      OP_RELEASE = 2'd1,
      OP_MARK    = 2'd2,
      OP_FORMAT  = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_RANGE = 2'd2
   } status_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic accept;      // latch the request and restart the counters
      logic sweep_en;    // write one map word at the sweep pointer
      logic sweep_zero;  // sweep writes zeros instead of the format pattern
      logic scan_en;     // read the next word and check the previous one
      logic bit_rd;      // read the word holding the latched block
      logic bit_wr;      // write that word back with the bit changed
      logic load_rsp;    // move the finished result to the output register
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic range_err;   // incoming block index at or above the managed span
      logic sweep_last;  // sweep pointer is on the last word
      logic scan_done;   // allocate found a block or reached the end of the span or map
      logic rsp_free;    // output register can take a result this cycle
   } stat_type;

endpackage

// ----- hdl/block_bitmap_allocator_unit.sv -----
// Release and mark pass through bit read, bit write and done; range errors go straight to done.
// Allocate scans one map word per cycle from word 0, a rate set by the single memory read
// port, until it finds a free block in the span or passes the span or the last map word.
// Format rewrites every map word, one per cycle.
// One item at a time; the next is taken while the last result waits in the output register.
// Reset (synchronous, active high) clears every map word in a sweep with req_tready low.
module block_bitmap_allocator_unit
   import bba_pkg::*;
#(
   parameter int TOTAL_BLOCKS  = DEF_TOTAL_BLOCKS,
   parameter int MAP_WORD_BITS = DEF_MAP_WORD_BITS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [15:0]        req_tdata,   // [14:0] block_index, [15] zero
   input  logic [OP_W-1:0]    req_tuser,   // [1:0] op
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [15:0]        rsp_tdata,   // [14:0] result_block, [15] zero
   output logic [STATUS_W-1:0] rsp_tuser,  // [1:0] status
   input  logic               csr_we,
   input  logic               csr_index,
   input  logic [CFG_W-1:0]   csr_wdata
);

   cmd_type            cmd;
   stat_type           stat;
   op_type             req_op;
   logic [BLOCK_W-1:0] rsp_block;
   status_type         rsp_status;

   assign req_op = op_type'(req_tuser);

   bba_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_op     (req_op),
      .stat       (stat),
      .cmd        (cmd)
   );

   bba_datapath #(
      .TOTAL_BLOCKS  (TOTAL_BLOCKS),
      .MAP_WORD_BITS (MAP_WORD_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_op           (req_op),
      .req_block_index  (req_tdata[BLOCK_W-1:0]),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_result_block (rsp_block),
      .rsp_status       (rsp_status),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .cmd              (cmd),
      .stat             (stat)
   );

   assign rsp_tdata = {1'b0, rsp_block};
   assign rsp_tuser = rsp_status;

endmodule

// ----- hdl/bba_ctrl.sv -----
// Controller state machine of the block bitmap allocator.
module bba_ctrl
   import bba_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   output logic     req_tready,
   input  op_type   req_op,
   input  stat_type stat,
   output cmd_type  cmd
);

   typedef enum logic [6:0] {
      S_CLEAR  = 7'b0000001,
      S_IDLE   = 7'b0000010,
      S_SCAN   = 7'b0000100,
      S_FORMAT = 7'b0001000,
      S_BIT_RD = 7'b0010000,
      S_BIT_WR = 7'b0100000,
      S_DONE   = 7'b1000000
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Decode state into commands and pick the next state
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            cmd.sweep_en   = 1'b1;
            cmd.sweep_zero = 1'b1;
            if (stat.sweep_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               case (req_op)
                  OP_ALLOC:   state_in = S_SCAN;
                  OP_FORMAT:  state_in = S_FORMAT;
                  OP_RELEASE,
                  OP_MARK:    state_in = stat.range_err ? S_DONE : S_BIT_RD;
                  default:    state_in = S_DONE;
               endcase
            end
         end
         S_SCAN: begin
            cmd.scan_en = 1'b1;
            if (stat.scan_done) begin
               state_in = S_DONE;
            end
         end
         S_FORMAT: begin
            cmd.sweep_en = 1'b1;
            if (stat.sweep_last) begin
               state_in = S_DONE;
            end
         end
         S_BIT_RD: begin
            cmd.bit_rd = 1'b1;
            state_in   = S_BIT_WR;
         end
         S_BIT_WR: begin
            cmd.bit_wr = 1'b1;
            state_in   = S_DONE;
         end
         S_DONE: begin
            if (stat.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Hold state; reset starts the map clearing sweep
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- hdl/bba_datapath.sv -----
// Datapath of the block bitmap allocator: map memory, scan, format sweep, registers.
module bba_datapath
   import bba_pkg::*;
#(
   parameter int TOTAL_BLOCKS  = DEF_TOTAL_BLOCKS,
   parameter int MAP_WORD_BITS = DEF_MAP_WORD_BITS
) (
   input  logic               clock,
   input  logic               reset,
   input  op_type             req_op,
   input  logic [BLOCK_W-1:0] req_block_index,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [BLOCK_W-1:0] rsp_result_block,
   output status_type         rsp_status,
   input  logic               csr_we,
   input  logic               csr_index,
   input  logic [CFG_W-1:0]   csr_wdata,
   input  cmd_type            cmd,
   output stat_type           stat
);

   localparam int W         = MAP_WORD_BITS;
   localparam int WB        = $clog2(MAP_WORD_BITS);
   localparam int MAP_WORDS = (TOTAL_BLOCKS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
   localparam int ADDR_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int MEM_DEPTH = 1 << ADDR_W;
   localparam int LIM_W     = $clog2(TOTAL_BLOCKS + 1);
   localparam int CMP_W     = (LIM_W > CFG_W) ? LIM_W : CFG_W;

   // Lowest set bit by halving, one level per index bit
   function automatic logic [WB-1:0] lowest_set(input logic [W-1:0] v);
      logic [W-1:0]  cur;
      logic [WB-1:0] pos;
      int            half;
      cur = v;
      pos = '0;
      for (int lvl = WB - 1; lvl >= 0; lvl--) begin
         half = 1 << lvl;
         if ((cur & ~({W{1'b1}} << half)) == '0) begin
            pos[lvl] = 1'b1;
            cur      = cur >> half;
         end
      end
      return pos;
   endfunction

   logic [CFG_W-1:0]   managed_ff;
   logic [CFG_W-1:0]   reserved_ff;
   op_type             op_ff;
   logic [BLOCK_W-1:0] idx_ff;
   logic [ADDR_W-1:0]  sweep_ptr_ff;
   logic [ADDR_W-1:0]  rd_ptr_ff;
   logic [ADDR_W-1:0]  scan_addr_ff;
   logic               scan_vld_ff;
   logic [BLOCK_W-1:0] res_block_ff;
   status_type         res_status_ff;
   logic               rsp_valid_ff;
   logic [BLOCK_W-1:0] rsp_block_ff;
   status_type         rsp_status_ff;
   logic [W-1:0]       map_mem_ff [MEM_DEPTH];
   logic [W-1:0]       rdata_ff;

   logic [CMP_W-1:0]   span;
   logic [CMP_W-1:0]   fmt_count;
   logic [CMP_W-1:0]   sweep_base;
   logic [WB-1:0]      fill_len;
   logic [W-1:0]       sweep_word;
   logic [CMP_W-1:0]   scan_base;
   logic [W-1:0]       free_bits;
   logic [WB-1:0]      low_pos;
   logic [CMP_W-1:0]   grant;
   logic               past_span;
   logic               hit;
   logic               miss;
   logic [ADDR_W-1:0]  bit_addr;
   logic [W-1:0]       bit_mask;
   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   logic [W-1:0]       wr_data;
   logic [ADDR_W-1:0]  rd_addr;
   logic               rel_or_mark;

   // Effective managed span and format count
   assign span      = (CMP_W'(managed_ff) > CMP_W'(TOTAL_BLOCKS)) ?
                      CMP_W'(TOTAL_BLOCKS) : CMP_W'(managed_ff);
   assign fmt_count = (CMP_W'(reserved_ff) < span) ? CMP_W'(reserved_ff) : span;

   // Format pattern of the word at the sweep pointer
   assign sweep_base = CMP_W'(sweep_ptr_ff) << WB;
   assign fill_len   = WB'(fmt_count - sweep_base);
   always_comb begin
      if (cmd.sweep_zero || fmt_count <= sweep_base) begin
         sweep_word = '0;
      end else if (fmt_count >= sweep_base + CMP_W'(W)) begin
         sweep_word = '1;
      end else begin
         sweep_word = ~({W{1'b1}} << fill_len);
      end
   end

   // Check the word read in the previous scan cycle
   assign scan_base = CMP_W'(scan_addr_ff) << WB;
   assign free_bits = ~rdata_ff;
   assign low_pos   = lowest_set(free_bits);
   assign grant     = scan_base + CMP_W'(low_pos);
   assign past_span = scan_base >= span;
   assign hit       = scan_vld_ff && !past_span && (|free_bits) && (grant < span);
   assign miss      = scan_vld_ff && !hit &&
                      (past_span || (|free_bits) ||
                       scan_addr_ff == ADDR_W'(MAP_WORDS - 1));

   // Word and bit of the latched block
   assign bit_addr = ADDR_W'(CMP_W'(idx_ff) >> WB);
   assign bit_mask = W'(1) << idx_ff[WB-1:0];

   // Select the memory write and read
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = sweep_ptr_ff;
      wr_data = sweep_word;
      if (cmd.sweep_en) begin
         wr_en = 1'b1;
      end else if (cmd.scan_en && hit) begin
         wr_en   = 1'b1;
         wr_addr = scan_addr_ff;
         wr_data = rdata_ff | (W'(1) << low_pos);
      end else if (cmd.bit_wr) begin
         wr_en   = 1'b1;
         wr_addr = bit_addr;
         wr_data = (op_ff == OP_MARK) ? (rdata_ff | bit_mask) : (rdata_ff & ~bit_mask);
      end
   end
   assign rd_addr = cmd.bit_rd ? bit_addr : rd_ptr_ff;

   // Map memory with registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         map_mem_ff[wr_addr] <= wr_data;
      end
      rdata_ff <= map_mem_ff[rd_addr];
   end

   // Status toward the controller
   assign rel_or_mark     = (req_op == OP_RELEASE) || (req_op == OP_MARK);
   assign stat.range_err  = CMP_W'(req_block_index) >= span;
   assign stat.sweep_last = sweep_ptr_ff == ADDR_W'(MEM_DEPTH - 1);
   assign stat.scan_done  = hit || miss;
   assign stat.rsp_free   = !rsp_valid_ff || rsp_tready;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         managed_ff  <= MANAGED_RESET;
         reserved_ff <= RESERVED_RESET;
      end else if (csr_we) begin
         if (csr_index == CSR_MANAGED) begin
            managed_ff <= csr_wdata;
         end
         if (csr_index == CSR_RESERVED) begin
            reserved_ff <= csr_wdata;
         end
      end
   end

   // Sweep and scan counters
   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ptr_ff <= '0;
         rd_ptr_ff    <= '0;
         scan_vld_ff  <= 1'b0;
      end else if (cmd.accept) begin
         sweep_ptr_ff <= '0;
         rd_ptr_ff    <= '0;
         scan_vld_ff  <= 1'b0;
      end else begin
         if (cmd.sweep_en) begin
            sweep_ptr_ff <= sweep_ptr_ff + 1'b1;
         end
         if (cmd.scan_en) begin
            rd_ptr_ff   <= rd_ptr_ff + 1'b1;
            scan_vld_ff <= 1'b1;
         end
      end
   end

   // Request fields and working result
   always_ff @(posedge clock) begin
      if (cmd.scan_en) begin
         scan_addr_ff <= rd_ptr_ff;
      end
      if (cmd.accept) begin
         op_ff         <= req_op;
         idx_ff        <= req_block_index;
         res_block_ff  <= rel_or_mark ? req_block_index : '0;
         res_status_ff <= (rel_or_mark && stat.range_err) ? ST_RANGE : ST_OK;
      end else if (cmd.scan_en && hit) begin
         res_block_ff  <= grant[BLOCK_W-1:0];
         res_status_ff <= ST_OK;
      end else if (cmd.scan_en && miss) begin
         res_block_ff  <= '0;
         res_status_ff <= ST_FULL;
      end
   end

   // Output register: load the finished result, drop it on transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_block_ff  <= res_block_ff;
         rsp_status_ff <= res_status_ff;
      end
   end

   assign rsp_tvalid       = rsp_valid_ff;
   assign rsp_result_block = rsp_block_ff;
   assign rsp_status       = rsp_status_ff;

   a_no_rsp_overrun: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (!rsp_valid_ff || rsp_tready))
      else $error("result loaded over a pending transfer");

   a_grant_in_span: assert property (@(posedge clock) disable iff (reset)
      (cmd.scan_en && hit) |-> (grant < span && !rdata_ff[low_pos]))
      else $error("allocate granted a used or unmanaged block");

   a_bit_in_span: assert property (@(posedge clock) disable iff (reset)
      cmd.bit_wr |-> (CMP_W'(idx_ff) < span))
      else $error("release or mark wrote a block outside the span");

   a_full_gives_zero: assert property (@(posedge clock) disable iff (reset)
      (cmd.load_rsp && res_status_ff == ST_FULL) |=> (rsp_block_ff == '0))
      else $error("no-space result carries a block number");

endmodule
